[rtl/core/fwdb_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package fwdb_pkg;

    localparam int FREQ_FRAC_BITS = 4;
    localparam int DB_FRAC_BITS   = 8;
    localparam int LOG_FRAC       = 24;
    localparam int FREQ_W         = 21;
    localparam int DB_W           = 16;
    localparam int XW             = 2 * FREQ_W;
    localparam int HW             = FREQ_W;
    localparam int PW             = XW + 1;
    localparam int LW             = 85;
    localparam int EW             = 7;
    localparam int LOGW           = EW + LOG_FRAC;
    localparam int NUM_LOGS       = 5;
    localparam int LOG_LAT        = 26;
    localparam int SUM_W          = 38;
    localparam int TOT_W          = 66;
    localparam int RND_SHIFT      = 49 - DB_FRAC_BITS;

    typedef enum logic [1:0] {
        CURVE_A = 2'd0,
        CURVE_B = 2'd1,
        CURVE_C = 2'd2,
        CURVE_D = 2'd3
    } t_curve;

    typedef struct packed {
        logic [FREQ_W-1:0] frequency;
        logic              last_bin;
    } t_fwdb_in;

    typedef struct packed {
        logic signed [DB_W-1:0] weight_db;
        logic                   last_out;
    } t_fwdb_out;

    typedef struct packed {
        logic   zero;
        logic   last;
        t_curve curve;
    } t_tag;

    function automatic logic [63:0] f_cq(input logic [63:0] c16);
        return (c16 + (64'd1 << (15 - 2 * FREQ_FRAC_BITS))) >> (16 - 2 * FREQ_FRAC_BITS);
    endfunction

    function automatic logic [LOGW-1:0] f_log2_q24(input logic [63:0] v);
        int          e;
        logic [63:0] m;
        logic [LOG_FRAC-1:0] fr;
        e  = 0;
        fr = '0;
        for (int i = 0; i < 64; i++) begin
            if (v[i]) e = i;
        end
        if (e >= 30) m = v >> (e - 30);
        else         m = v << (30 - e);
        for (int k = 0; k < LOG_FRAC; k++) begin
            m = (m * m) >> 30;
            if (m[31]) begin
                m = m >> 1;
                fr[LOG_FRAC-1-k] = 1'b1;
            end
        end
        return {EW'(e), fr};
    endfunction

    localparam logic [PW-1:0] CQ_12200  = PW'(f_cq(64'd9754378240000));
    localparam logic [PW-1:0] CQ_20_6   = PW'(f_cq(64'd27810857));
    localparam logic [PW-1:0] CQ_107_7  = PW'(f_cq(64'd760171069));
    localparam logic [PW-1:0] CQ_737_9  = PW'(f_cq(64'd35684116726));
    localparam logic [PW-1:0] CQ_12194  = PW'(f_cq(64'd9744786128896));
    localparam logic [PW-1:0] CQ_158_5  = PW'(f_cq(64'd1646411776));
    localparam logic [PW-1:0] CQ_1018_7 = PW'(f_cq(64'd68009963684));
    localparam logic [PW-1:0] CQ_1039_6 = PW'(f_cq(64'd70829156598));
    localparam logic [PW-1:0] CQ_3136_5 = PW'(f_cq(64'd644719067136));
    localparam logic [PW-1:0] CQ_3424   = PW'(f_cq(64'd768329383936));
    localparam logic [PW-1:0] CQ_282_7  = PW'(f_cq(64'd5237590589));
    localparam logic [PW-1:0] CQ_1160   = PW'(f_cq(64'd88185241600));

    localparam logic [LOGW-1:0] LG_C0A = f_log2_q24(f_cq(64'd9754378240000));
    localparam logic [LOGW-1:0] LG_C0B = f_log2_q24(f_cq(64'd9744786128896));

    localparam logic [SUM_W-1:0] D_BIAS = SUM_W'(2 * FREQ_FRAC_BITS) << LOG_FRAC;
    localparam logic [26:0]      K_DB   = 27'd101008905;

    localparam logic [22:0] OFF_A = 23'd131072;
    localparam logic [22:0] OFF_B = 23'd11141;
    localparam logic [22:0] OFF_C = 23'd4063;
    localparam logic [22:0] OFF_D = 23'd5454377;

    localparam logic signed [DB_W-1:0] FLOOR_DB = DB_W'(-80 * (2 ** DB_FRAC_BITS));
    localparam logic signed [DB_W-1:0] MAX_DB   = DB_W'(32767);

endpackage
`default_nettype wire

[rtl/core/fwdb_log2.sv]
`timescale 1ns / 1ps
`default_nettype none
module fwdb_log2 (
    input  wire logic                          i_clk,
    input  wire logic [fwdb_pkg::LW-1:0]       i_v,
    output logic      [fwdb_pkg::LOGW-1:0]     o_log
);

    localparam int NSTG = fwdb_pkg::LOG_FRAC;
    localparam int EW   = fwdb_pkg::EW;
    localparam int LW   = fwdb_pkg::LW;

    logic [LW-1:0]       r_v;
    logic [EW-1:0]       r_e0;
    logic [EW-1:0]       n_e0;
    logic [30:0]         r_m  [0:NSTG];
    logic [EW-1:0]       r_e  [0:NSTG];
    logic [NSTG-1:0]     r_fr [0:NSTG];

    always_comb begin
        n_e0 = '0;
        for (int i = 0; i < LW; i++) begin
            if (i_v[i]) n_e0 = EW'(i);
        end
    end

    always_ff @(posedge i_clk) begin
        r_v     <= i_v;
        r_e0    <= n_e0;
        r_m[0]  <= 31'(({r_v, 30'b0} >> r_e0));
        r_e[0]  <= r_e0;
        r_fr[0] <= '0;
    end

    genvar g;
    generate
        for (g = 0; g < NSTG; g++) begin : g_sq
            logic [61:0] w_prod;
            logic [31:0] w_q;
            assign w_prod = 62'(r_m[g]) * 62'(r_m[g]);
            assign w_q    = w_prod[61:30];
            always_ff @(posedge i_clk) begin
                r_e[g+1]  <= r_e[g];
                if (w_q[31]) begin
                    r_m[g+1]  <= w_q[31:1];
                    r_fr[g+1] <= r_fr[g] | (NSTG'(1) << (NSTG - 1 - g));
                end else begin
                    r_m[g+1]  <= w_q[30:0];
                    r_fr[g+1] <= r_fr[g];
                end
            end
        end
    endgenerate

    assign o_log = {r_e[NSTG], r_fr[NSTG]};

endmodule
`default_nettype wire

[rtl/core/frequency_weighting_db_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// A result strobes on o_valid once its item has passed the whole pipeline; a valid bit shifts alongside it.
// Throughput: one item per cycle; busy is low whenever reset is released.
// The depth is set by the five parallel log2 units, 24 squaring stages each.
// Reset clears the valid line and selects curve A; items in flight are dropped.
// The receiver cannot stall, so the pipeline advances every cycle.
module frequency_weighting_db_unit (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    output logic                      o_busy,
    input  wire fwdb_pkg::t_fwdb_in   i_item,
    input  wire logic                 i_cfg_wr_en,
    input  wire logic [1:0]           i_cfg_wr_data,
    output logic                      o_valid,
    output fwdb_pkg::t_fwdb_out       o_result
);

    localparam int LAT   = 36;
    localparam int NTAG  = LAT - 1;
    localparam int XW    = fwdb_pkg::XW;
    localparam int HW    = fwdb_pkg::HW;
    localparam int PW    = fwdb_pkg::PW;
    localparam int LW    = fwdb_pkg::LW;
    localparam int LOGW  = fwdb_pkg::LOGW;
    localparam int NL    = fwdb_pkg::NUM_LOGS;
    localparam int SW    = fwdb_pkg::SUM_W;
    localparam int TW    = fwdb_pkg::TOT_W;
    localparam int RS    = fwdb_pkg::RND_SHIFT;
    localparam int QW    = TW - RS;
    localparam int BW    = 32;
    localparam int SPLIT = 19;

    fwdb_pkg::t_curve r_curve;
    logic [LAT-1:0]   r_vld;
    fwdb_pkg::t_tag   r_tag [0:NTAG-1];
    fwdb_pkg::t_tag   n_tag;

    logic [fwdb_pkg::FREQ_W-1:0] r_f;
    logic [XW-1:0]    r_x;
    logic [PW-1:0]    r_p2 [0:NL-1];
    logic [XW-1:0]    r_dn, r_dd;
    logic [PW-1:0]    n_p2 [0:NL-1];
    logic [XW-1:0]    n_dn, n_dd;
    logic [PW-1:0]    r_p3 [0:NL-1];
    logic [XW-1:0]    r_nhh, r_nhl, r_nll, r_dhh, r_dhl, r_dll;
    logic [HW+BW-1:0] r_nbl, r_nbh, r_dbl, r_dbh;
    logic [PW-1:0]    r_p4 [0:NL-1];
    logic [2*XW-1:0]  r_ndsq, r_ddsq;
    logic [HW+XW+BW-HW-1+HW-HW:0] r_nbx, r_dbx;
    logic [LW-1:0]    r_v5 [0:NL-1];
    logic [LOGW-1:0]  w_log [0:NL-1];
    logic signed [SW-1:0] w_l [0:NL-1];
    logic signed [SW-1:0] n_sum, r_sum;
    logic [SPLIT+27-1:0]  r_plo;
    logic signed [SW-SPLIT+28-1:0] r_phi;
    logic signed [TW-1:0] n_total, r_total;
    logic [22:0]          n_off;
    logic [TW-1:0]        n_mag, n_rnd;
    logic [QW-1:0]        n_q;
    logic signed [QW:0]   n_res;
    fwdb_pkg::t_fwdb_out  n_out, r_out;

    assign o_busy = !i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_curve <= fwdb_pkg::CURVE_A;
            r_vld   <= '0;
        end else begin
            if (i_cfg_wr_en) r_curve <= fwdb_pkg::t_curve'(i_cfg_wr_data);
            r_vld <= {r_vld[LAT-2:0], i_start};
        end
    end

    always_comb begin
        n_tag.zero  = (i_item.frequency == '0);
        n_tag.last  = i_item.last_bin;
        n_tag.curve = r_curve;
    end

    always_ff @(posedge i_clk) begin
        r_tag[0] <= n_tag;
        for (int i = 1; i < NTAG; i++) r_tag[i] <= r_tag[i-1];
    end

    // operand build
    always_comb begin
        n_p2[0] = PW'(r_x);
        n_p2[1] = PW'(r_x) + ((r_tag[1].curve == fwdb_pkg::CURVE_A) ?
                  fwdb_pkg::CQ_12200 : fwdb_pkg::CQ_12194);
        n_p2[2] = PW'(r_x) + fwdb_pkg::CQ_20_6;
        case (r_tag[1].curve)
            fwdb_pkg::CURVE_A: begin
                n_p2[3] = PW'(r_x) + fwdb_pkg::CQ_107_7;
                n_p2[4] = PW'(r_x) + fwdb_pkg::CQ_737_9;
            end
            fwdb_pkg::CURVE_B: begin
                n_p2[3] = PW'(r_x) + fwdb_pkg::CQ_158_5;
                n_p2[4] = PW'(r_x);
            end
            fwdb_pkg::CURVE_D: begin
                n_p2[3] = PW'(r_x) + fwdb_pkg::CQ_282_7;
                n_p2[4] = PW'(r_x) + fwdb_pkg::CQ_1160;
            end
            default: begin
                n_p2[3] = PW'(r_x);
                n_p2[4] = PW'(r_x);
            end
        endcase
        n_dn = (r_x > XW'(fwdb_pkg::CQ_1018_7)) ? r_x - XW'(fwdb_pkg::CQ_1018_7)
                                                : XW'(fwdb_pkg::CQ_1018_7) - r_x;
        n_dd = (r_x > XW'(fwdb_pkg::CQ_3136_5)) ? r_x - XW'(fwdb_pkg::CQ_3136_5)
                                                : XW'(fwdb_pkg::CQ_3136_5) - r_x;
    end

    always_ff @(posedge i_clk) begin
        r_f <= i_item.frequency;
        r_x <= XW'(r_f) * XW'(r_f);
        r_p2 <= n_p2;
        r_dn <= n_dn;
        r_dd <= n_dd;

        r_p3  <= r_p2;
        r_nhh <= XW'(r_dn[XW-1:HW]) * XW'(r_dn[XW-1:HW]);
        r_nhl <= XW'(r_dn[XW-1:HW]) * XW'(r_dn[HW-1:0]);
        r_nll <= XW'(r_dn[HW-1:0])  * XW'(r_dn[HW-1:0]);
        r_dhh <= XW'(r_dd[XW-1:HW]) * XW'(r_dd[XW-1:HW]);
        r_dhl <= XW'(r_dd[XW-1:HW]) * XW'(r_dd[HW-1:0]);
        r_dll <= XW'(r_dd[HW-1:0])  * XW'(r_dd[HW-1:0]);
        r_nbl <= (HW+BW)'(fwdb_pkg::CQ_1039_6) * (HW+BW)'(r_p2[0][HW-1:0]);
        r_nbh <= (HW+BW)'(fwdb_pkg::CQ_1039_6) * (HW+BW)'(r_p2[0][XW-1:HW]);
        r_dbl <= (HW+BW)'(fwdb_pkg::CQ_3424)   * (HW+BW)'(r_p2[0][HW-1:0]);
        r_dbh <= (HW+BW)'(fwdb_pkg::CQ_3424)   * (HW+BW)'(r_p2[0][XW-1:HW]);

        r_p4   <= r_p3;
        r_ndsq <= ((2*XW)'(r_nhh) << XW) + ((2*XW)'(r_nhl) << (HW + 1)) + (2*XW)'(r_nll);
        r_ddsq <= ((2*XW)'(r_dhh) << XW) + ((2*XW)'(r_dhl) << (HW + 1)) + (2*XW)'(r_dll);
        r_nbx  <= ($bits(r_nbx))'(($bits(r_nbx))'(r_nbh) << HW) + ($bits(r_nbx))'(r_nbl);
        r_dbx  <= ($bits(r_dbx))'(($bits(r_dbx))'(r_dbh) << HW) + ($bits(r_dbx))'(r_dbl);

        r_v5[0] <= LW'(r_p4[0]);
        r_v5[3] <= LW'(r_p4[3]);
        r_v5[4] <= LW'(r_p4[4]);
        if (r_tag[4].curve == fwdb_pkg::CURVE_D) begin
            r_v5[1] <= LW'(r_ndsq) + LW'(r_nbx);
            r_v5[2] <= LW'(r_ddsq) + LW'(r_dbx);
        end else begin
            r_v5[1] <= LW'(r_p4[1]);
            r_v5[2] <= LW'(r_p4[2]);
        end
    end

    genvar g;
    generate
        for (g = 0; g < NL; g++) begin : g_log
            fwdb_log2 u_log (
                .i_clk (i_clk),
                .i_v   (r_v5[g]),
                .o_log (w_log[g])
            );
            assign w_l[g] = $signed({{(SW-LOGW){1'b0}}, w_log[g]});
        end
    endgenerate

    always_comb begin
        case (r_tag[LAT-5].curve)
            fwdb_pkg::CURVE_A: n_sum = ($signed(SW'(fwdb_pkg::LG_C0A)) <<< 1) + (w_l[0] <<< 2)
                                     - (w_l[1] <<< 1) - (w_l[2] <<< 1) - w_l[3] - w_l[4];
            fwdb_pkg::CURVE_B: n_sum = ($signed(SW'(fwdb_pkg::LG_C0B)) <<< 1) + (w_l[0] <<< 1)
                                     + w_l[0] - (w_l[1] <<< 1) - (w_l[2] <<< 1) - w_l[3];
            fwdb_pkg::CURVE_C: n_sum = ($signed(SW'(fwdb_pkg::LG_C0B)) <<< 1) + (w_l[0] <<< 1)
                                     - (w_l[1] <<< 1) - (w_l[2] <<< 1);
            default:           n_sum = w_l[0] + w_l[1] - w_l[2] - w_l[3] - w_l[4]
                                     + $signed(fwdb_pkg::D_BIAS);
        endcase
    end

    always_comb begin
        case (r_tag[LAT-3].curve)
            fwdb_pkg::CURVE_A: n_off = fwdb_pkg::OFF_A;
            fwdb_pkg::CURVE_B: n_off = fwdb_pkg::OFF_B;
            fwdb_pkg::CURVE_C: n_off = fwdb_pkg::OFF_C;
            default:           n_off = fwdb_pkg::OFF_D;
        endcase
        n_total = (TW'(r_phi) <<< SPLIT) + $signed(TW'(r_plo))
                + $signed(TW'(n_off) << 33);
    end

    always_comb begin
        n_mag = r_total[TW-1] ? TW'(-r_total) : TW'(r_total);
        n_rnd = n_mag + (TW'(1) << (RS - 1));
        n_q   = n_rnd[TW-1:RS];
        n_res = r_total[TW-1] ? -$signed({1'b0, n_q}) : $signed({1'b0, n_q});
        n_out.last_out = r_tag[LAT-2].last;
        if (r_tag[LAT-2].zero || n_res < (QW+1)'(fwdb_pkg::FLOOR_DB)) begin
            n_out.weight_db = fwdb_pkg::FLOOR_DB;
        end else if (n_res > (QW+1)'(fwdb_pkg::MAX_DB)) begin
            n_out.weight_db = fwdb_pkg::MAX_DB;
        end else begin
            n_out.weight_db = n_res[fwdb_pkg::DB_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum   <= n_sum;
        r_plo   <= ($bits(r_plo))'(r_sum[SPLIT-1:0]) * ($bits(r_plo))'(fwdb_pkg::K_DB);
        r_phi   <= ($bits(r_phi))'($signed(r_sum[SW-1:SPLIT]))
                 * ($bits(r_phi))'($signed({1'b0, fwdb_pkg::K_DB}));
        r_total <= n_total;
        r_out   <= n_out;
    end

    assign o_valid  = r_vld[LAT-1];
    assign o_result = r_out;

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##36 o_valid)
        else $error("item did not produce a result on time");

    a_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_result.weight_db >= fwdb_pkg::FLOOR_DB))
        else $error("result below the floor");

    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && i_item.frequency == '0)
        |-> ##36 (o_result.weight_db == fwdb_pkg::FLOOR_DB))
        else $error("zero frequency did not give the floor");

    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##36 (o_result.last_out == $past(i_item.last_bin, 36)))
        else $error("last marker lost");

endmodule
`default_nettype wire

[dv/testbench.sv]
`timescale 1ns / 1ps
module testbench;

    class weight_scoreboard;
        fwdb_pkg::t_fwdb_out expected_q[$];
        int                  mismatches;

        function new();
            mismatches = 0;
        endfunction

        function longint unsigned cq(longint unsigned c16);
            return (c16 + 64'd128) >> 8;
        endfunction

        function longint log2_q24(logic [127:0] v);
            int                e;
            longint unsigned   m;
            longint            frac;
            e = 0;
            frac = 0;
            if (v == 0) return 0;
            for (int i = 0; i < 128; i++) begin
                if (v[i]) e = i;
            end
            if (e >= 30) m = 64'(v >> (e - 30));
            else         m = 64'(v << (30 - e));
            for (int k = 0; k < 24; k++) begin
                m = (m * m) >> 30;
                if (m >= 64'h8000_0000) begin
                    m = m >> 1;
                    frac = frac | (64'd1 << (23 - k));
                end
            end
            return longint'(e) * 64'sd16777216 + frac;
        endfunction

        function logic [127:0] sq_diff_plus(longint unsigned a, longint unsigned x,
                                            longint unsigned b);
            logic [127:0] d;
            d = (a > x) ? (a - x) : (x - a);
            return d * d + 128'(b) * 128'(x);
        endfunction

        function logic signed [15:0] weight_of(logic [20:0] freq, fwdb_pkg::t_curve curve);
            longint unsigned f, x, c0, mag;
            longint          s2, off, total, res;
            f = freq;
            if (f == 0) return fwdb_pkg::FLOOR_DB;
            x = f * f;
            case (curve)
                fwdb_pkg::CURVE_A: begin
                    c0 = cq(64'd9754378240000);
                    s2 = 2 * log2_q24(c0) + 4 * log2_q24(x) - 2 * log2_q24(x + c0)
                         - 2 * log2_q24(x + cq(64'd27810857))
                         - log2_q24(x + cq(64'd760171069))
                         - log2_q24(x + cq(64'd35684116726));
                    off = 131072;
                end
                fwdb_pkg::CURVE_B: begin
                    c0 = cq(64'd9744786128896);
                    s2 = 2 * log2_q24(c0) + 3 * log2_q24(x) - 2 * log2_q24(x + c0)
                         - 2 * log2_q24(x + cq(64'd27810857))
                         - log2_q24(x + cq(64'd1646411776));
                    off = 11141;
                end
                fwdb_pkg::CURVE_C: begin
                    c0 = cq(64'd9744786128896);
                    s2 = 2 * log2_q24(c0) + 2 * log2_q24(x) - 2 * log2_q24(x + c0)
                         - 2 * log2_q24(x + cq(64'd27810857));
                    off = 4063;
                end
                default: begin
                    s2 = log2_q24(x)
                         + log2_q24(sq_diff_plus(cq(64'd68009963684), x,
                                                 cq(64'd70829156598)))
                         - log2_q24(sq_diff_plus(cq(64'd644719067136), x,
                                                 cq(64'd768329383936)))
                         - log2_q24(x + cq(64'd5237590589))
                         - log2_q24(x + cq(64'd88185241600))
                         + 64'sd8 * 64'sd16777216;
                    off = 5454377;
                end
            endcase
            total = s2 * 64'sd101008905 + off * 64'sd8589934592;
            if (total < 0) begin
                mag = -total;
                res = -longint'((mag + (64'd1 << 40)) >> 41);
            end else begin
                mag = total;
                res = longint'((mag + (64'd1 << 40)) >> 41);
            end
            if (res < -20480) res = -20480;
            if (res > 32767) res = 32767;
            return 16'(res);
        endfunction

        function void note_bin(fwdb_pkg::t_fwdb_in bin, fwdb_pkg::t_curve curve);
            fwdb_pkg::t_fwdb_out w;
            w.weight_db = weight_of(bin.frequency, curve);
            w.last_out  = bin.last_bin;
            expected_q.push_back(w);
        endfunction

        function void check_weight(fwdb_pkg::t_fwdb_out got);
            fwdb_pkg::t_fwdb_out w;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: weight %0d last %0b",
                             got.weight_db, got.last_out);
                return;
            end
            w = expected_q.pop_front();
            if (got.weight_db !== w.weight_db || got.last_out !== w.last_out) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected weight %0d last %0b, got weight %0d last %0b",
                             w.weight_db, w.last_out, got.weight_db, got.last_out);
            end
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                i_start;
    logic                o_busy;
    fwdb_pkg::t_fwdb_in  i_item;
    logic                i_cfg_wr_en;
    logic [1:0]          i_cfg_wr_data;
    logic                o_valid;
    fwdb_pkg::t_fwdb_out o_result;

    weight_scoreboard sb;
    fwdb_pkg::t_curve active_curve;
    int               idle_cycles;
    bit               calm;

    frequency_weighting_db_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_start),
        .o_busy        (o_busy),
        .i_item        (i_item),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_valid       (o_valid),
        .o_result      (o_result)
    );

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_start && !o_busy) sb.note_bin(i_item, active_curve);
            if (o_valid) sb.check_weight(o_result);
            if ((i_start && !o_busy) || o_valid) idle_cycles = 0;
            else                                 idle_cycles++;
            if (idle_cycles >= 3000) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    task automatic send_bin(logic [20:0] freq, logic last);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_item.frequency <= freq;
        i_item.last_bin  <= last;
        do @(posedge i_clk); while (o_busy);
    endtask

    task automatic select_curve(fwdb_pkg::t_curve c);
        i_start <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= c;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        active_curve = c;
    endtask

    function automatic logic [20:0] random_freq();
        case ($urandom_range(0, 3))
            0: return 21'($urandom);
            1: return 21'($urandom_range(0, 1536000));
            default: return 21'($urandom >> $urandom_range(11, 31));
        endcase
    endfunction

    initial begin
        fwdb_pkg::t_curve order[7];
        logic [20:0] directed[6];
        sb = new();
        idle_cycles = 0;
        calm = 0;
        active_curve = fwdb_pkg::CURVE_A;
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_item = '0;
        i_cfg_wr_en = 1'b0;
        i_cfg_wr_data = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        directed = '{21'd0, 21'd1, 21'd16000, 21'd1536000, 21'h1FFFFF, 21'h0AAAAA};
        order = '{fwdb_pkg::CURVE_A, fwdb_pkg::CURVE_B, fwdb_pkg::CURVE_C, fwdb_pkg::CURVE_D,
                  fwdb_pkg::CURVE_A, fwdb_pkg::CURVE_D, fwdb_pkg::CURVE_B};
        for (int c = 0; c < 4; c++) begin
            select_curve(fwdb_pkg::t_curve'(c));
            foreach (directed[i]) send_bin(directed[i], i[0]);
        end
        foreach (order[p]) begin
            select_curve(order[p]);
            for (int n = 0; n < 150; n++) begin
                if ($urandom_range(0, 39) == 0) calm = !calm;
                send_bin(random_freq(), $urandom_range(0, 7) == 0);
            end
            calm = 0;
        end
        i_start <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.expected_q.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

[files.f]
rtl/core/fwdb_pkg.sv
rtl/core/fwdb_log2.sv
rtl/core/frequency_weighting_db_unit.sv
dv/testbench.sv
